// ===== sv/dcls_pkg.sv =====
// Shared types, constants and codes for the depth compositing Lambert shader.
// Used by dcls_pixel_mem, dcls_shade and depth_composite_lambert_shader.
`timescale 1ns / 1ps

package dcls_pkg;

    // Pixel store geometry
    localparam int PIXEL_COUNT  = 65536;
    localparam int PIX_ADDR_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int INDEX_W      = 16;
    localparam int IDX_CMP_W    = 25;

    // Shading constants, Q14
    localparam logic [16:0] LUM_BASE    = 17'd5243;
    localparam logic [13:0] LUM_GAIN    = 14'd11141;
    // floor(2^31 / 127), quotient estimate for the divide by 127
    localparam logic [24:0] RECIP_127   = 25'd16909320;
    localparam logic [7:0]  DIV_127     = 8'd127;

    // Default material and background colors
    localparam logic [7:0] DEF_RED   = 8'd228;
    localparam logic [7:0] DEF_GREEN = 8'd219;
    localparam logic [7:0] DEF_BLUE  = 8'd205;
    localparam logic [7:0] BG_RED    = 8'd28;
    localparam logic [7:0] BG_GREEN  = 8'd26;
    localparam logic [7:0] BG_BLUE   = 8'd24;
    localparam logic [7:0] ALPHA_ON  = 8'd255;
    localparam logic [7:0] ALPHA_OFF = 8'd0;
    localparam logic [7:0] FLAT_NX   = 8'd128;
    localparam logic [7:0] FLAT_NY   = 8'd128;
    localparam logic [7:0] FLAT_NZ   = 8'd255;

    // Light register reset values
    localparam logic [15:0] LIGHT_X_RST = 16'd5407;
    localparam logic [15:0] LIGHT_Y_RST = 16'd5243;
    localparam logic [15:0] LIGHT_Z_RST = 16'd14582;

    // Opcodes
    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LIGHT_X     = 3'd0,
        CFG_LIGHT_Y     = 3'd1,
        CFG_LIGHT_Z     = 3'd2,
        CFG_FLAT_MODE   = 3'd3,
        CFG_TRANSP_BG   = 3'd4
    } cfg_index_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SHADE,
        ST_EMIT
    } state_t;

    // One stored pixel
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  nz;
        logic [7:0]  ny;
        logic [7:0]  nx;
        logic [15:0] depth;
    } pixel_t;

    // Key light direction, signed Q1.14
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } light_t;

    // Request into the shading unit
    typedef struct packed {
        logic       start;
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } shade_req_t;

    // Result from the shading unit
    typedef struct packed {
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } shade_rsp_t;

endpackage

// ===== sv/dcls_pixel_mem.sv =====
// Pixel store: one synchronous memory of depth, normal and color per pixel.
// Runs a clearing pass after reset. Depends on dcls_pkg.
`timescale 1ns / 1ps

module dcls_pixel_mem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [dcls_pkg::PIX_ADDR_W-1:0] rd_addr,
    output dcls_pkg::pixel_t                rd_data,
    input  logic                            wr_en,
    input  logic [dcls_pkg::PIX_ADDR_W-1:0] wr_addr,
    input  dcls_pkg::pixel_t                wr_data,
    output logic                            clear_busy
);

    dcls_pkg::pixel_t                mem_array [dcls_pkg::PIXEL_COUNT];
    dcls_pkg::pixel_t                rd_data_reg;
    logic                            clr_busy_reg;
    logic                            clr_busy_next;
    logic [dcls_pkg::PIX_ADDR_W-1:0] clr_addr_reg;
    logic [dcls_pkg::PIX_ADDR_W-1:0] clr_addr_next;
    logic                            mem_we;
    logic [dcls_pkg::PIX_ADDR_W-1:0] mem_waddr;
    dcls_pkg::pixel_t                mem_wdata;

    // Advance the clearing sweep one entry a cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == dcls_pkg::PIX_ADDR_W'(dcls_pkg::PIXEL_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Select sweep or user write
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ===== sv/dcls_shade.sv =====
// Six-stage Lambert shading unit: dot product, divide by 127, luminance,
// per-channel scale and saturation. Depends on dcls_pkg.
`timescale 1ns / 1ps

module dcls_shade (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dcls_pkg::light_t     light,
    input  dcls_pkg::shade_req_t req,
    output dcls_pkg::shade_rsp_t rsp
);

    logic [5:0]         vld_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic signed [8:0]  dz;
    logic signed [24:0] px_reg;
    logic signed [24:0] py_reg;
    logic signed [24:0] pz_reg;
    logic signed [25:0] dot_sum;
    logic [23:0]        dotp_reg;
    logic [48:0]        recip_prod;
    logic [16:0]        q0_reg;
    logic [23:0]        dotp2_reg;
    logic [23:0]        q0_times;
    logic [23:0]        rem;
    logic [16:0]        diff_reg;
    logic [30:0]        gain_prod;
    logic [16:0]        lum_reg;
    logic [24:0]        cr_reg;
    logic [24:0]        cg_reg;
    logic [24:0]        cb_reg;

    // Track which stage holds the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], req.start};
        end
    end

    // Stage 1: centered normal times light, per axis
    assign dx = $signed({1'b0, req.nx}) - 9'sd128;
    assign dy = $signed({1'b0, req.ny}) - 9'sd128;
    assign dz = $signed({1'b0, req.nz}) - 9'sd128;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            px_reg    <= dx * light.x;
            py_reg    <= dy * light.y;
            pz_reg    <= dz * light.z;
            red_reg   <= req.red;
            green_reg <= req.green;
            blue_reg  <= req.blue;
        end
    end

    // Stage 2: sum and clamp at zero
    assign dot_sum = 26'(px_reg) + 26'(py_reg) + 26'(pz_reg);

    always_ff @(posedge clk)
    begin
        if (vld_reg[0])
        begin
            dotp_reg <= (dot_sum > 26'sd0) ? dot_sum[23:0] : 24'd0;
        end
    end

    // Stage 3: quotient estimate by reciprocal, low by at most one
    assign recip_prod = 49'(dotp_reg) * 49'(dcls_pkg::RECIP_127);

    always_ff @(posedge clk)
    begin
        if (vld_reg[1])
        begin
            q0_reg    <= recip_prod[47:31];
            dotp2_reg <= dotp_reg;
        end
    end

    // Stage 4: correct the estimate from the remainder
    assign q0_times = {q0_reg, 7'd0} - 24'(q0_reg);
    assign rem      = dotp2_reg - q0_times;

    always_ff @(posedge clk)
    begin
        if (vld_reg[2])
        begin
            diff_reg <= (rem >= 24'(dcls_pkg::DIV_127)) ? q0_reg + 1'b1 : q0_reg;
        end
    end

    // Stage 5: luminance = base + gain * diff
    assign gain_prod = 31'(diff_reg) * 31'(dcls_pkg::LUM_GAIN);

    always_ff @(posedge clk)
    begin
        if (vld_reg[3])
        begin
            lum_reg <= dcls_pkg::LUM_BASE + gain_prod[30:14];
        end
    end

    // Stage 6: scale each channel
    always_ff @(posedge clk)
    begin
        if (vld_reg[4])
        begin
            cr_reg <= 25'(red_reg) * 25'(lum_reg);
            cg_reg <= 25'(green_reg) * 25'(lum_reg);
            cb_reg <= 25'(blue_reg) * 25'(lum_reg);
        end
    end

    // Drop the fraction and saturate
    always_comb
    begin
        rsp.done  = vld_reg[5];
        rsp.red   = (cr_reg[24:22] != 3'd0) ? 8'd255 : cr_reg[21:14];
        rsp.green = (cg_reg[24:22] != 3'd0) ? 8'd255 : cg_reg[21:14];
        rsp.blue  = (cb_reg[24:22] != 3'd0) ? 8'd255 : cb_reg[21:14];
    end

endmodule

// ===== sv/depth_composite_lambert_shader.sv =====
// Top level of the depth compositing Lambert shader: sequencer, registers,
// output stage. Depends on dcls_pkg, dcls_pixel_mem and dcls_shade.
`timescale 1ns / 1ps

// Merge items keep the nearest (largest depth) sample per pixel; read items
// shade the pixel, emit one result and clear it. Items are handled one at a
// time through the pixel memory: a merge reads the entry, then writes it
// back; a read reads the entry and clears it if in range, waits for the
// six-stage shading unit if the pixel is covered, then emits. The
// output register lets the next item enter while a result waits. After reset
// a clearing pass zeroes the store, one entry a cycle, across all PIXEL_COUNT
// (65536) entries before the first item is accepted; configuration writes are
// taken throughout.

module depth_composite_lambert_shader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] pixel_index,
    input  logic [15:0] sample_depth,
    input  logic [7:0]  normal_x,
    input  logic [7:0]  normal_y,
    input  logic [7:0]  normal_z,
    input  logic signed [8:0] shape_red,
    input  logic signed [8:0] shape_green,
    input  logic signed [8:0] shape_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_index,
    output logic        covered,
    output logic [7:0]  alpha,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    dcls_pkg::state_t     state_reg;
    dcls_pkg::state_t     state_next;
    dcls_pkg::light_t     light_reg;
    logic                 flat_reg;
    logic                 transp_reg;

    logic                 op_reg;
    logic [15:0]          idx_reg;
    logic [15:0]          depth_reg;
    logic [7:0]           nx_reg;
    logic [7:0]           ny_reg;
    logic [7:0]           nz_reg;
    logic [8:0]           sr_reg;
    logic [8:0]           sg_reg;
    logic [8:0]           sb_reg;
    logic                 covered_reg;
    logic                 covered_next;

    logic                 out_valid_reg;
    logic [15:0]          out_index_reg;
    logic                 covered_out_reg;
    logic [7:0]           alpha_reg;
    logic [7:0]           red_reg;
    logic [7:0]           green_reg;
    logic [7:0]           blue_reg;

    logic                 accept;
    logic                 idx_ok;
    logic [dcls_pkg::INDEX_W+dcls_pkg::PIX_ADDR_W-1:0] in_addr_wide;
    logic [dcls_pkg::INDEX_W+dcls_pkg::PIX_ADDR_W-1:0] hold_addr_wide;
    logic [dcls_pkg::PIX_ADDR_W-1:0] rd_addr;
    logic [dcls_pkg::PIX_ADDR_W-1:0] wr_addr;
    dcls_pkg::pixel_t     rd_data;
    dcls_pkg::pixel_t     wr_data;
    dcls_pkg::pixel_t     merge_data;
    logic                 mem_rd_en;
    logic                 mem_wr_en;
    logic                 clear_busy;
    logic                 out_load;
    logic                 merge_win;
    dcls_pkg::shade_req_t shade_req;
    dcls_pkg::shade_rsp_t shade_rsp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg.x <= dcls_pkg::LIGHT_X_RST;
            light_reg.y <= dcls_pkg::LIGHT_Y_RST;
            light_reg.z <= dcls_pkg::LIGHT_Z_RST;
            flat_reg    <= 1'b0;
            transp_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcls_pkg::CFG_LIGHT_X:   light_reg.x <= cfg_data;
                dcls_pkg::CFG_LIGHT_Y:   light_reg.y <= cfg_data;
                dcls_pkg::CFG_LIGHT_Z:   light_reg.z <= cfg_data;
                dcls_pkg::CFG_FLAT_MODE: flat_reg    <= cfg_data[0];
                dcls_pkg::CFG_TRANSP_BG: transp_reg  <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // Hold the accepted item
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            idx_reg   <= pixel_index;
            depth_reg <= sample_depth;
            nx_reg    <= normal_x;
            ny_reg    <= normal_y;
            nz_reg    <= normal_z;
            sr_reg    <= shape_red;
            sg_reg    <= shape_green;
            sb_reg    <= shape_blue;
        end
    end

    // Map pixel indexes to memory addresses
    assign in_addr_wide   = {{dcls_pkg::PIX_ADDR_W{1'b0}}, pixel_index};
    assign hold_addr_wide = {{dcls_pkg::PIX_ADDR_W{1'b0}}, idx_reg};
    assign rd_addr        = in_addr_wide[dcls_pkg::PIX_ADDR_W-1:0];
    assign wr_addr        = hold_addr_wide[dcls_pkg::PIX_ADDR_W-1:0];
    assign idx_ok = dcls_pkg::IDX_CMP_W'(idx_reg) <
                    dcls_pkg::IDX_CMP_W'(dcls_pkg::PIXEL_COUNT);

    // Build the merged entry
    always_comb
    begin
        merge_data.depth = depth_reg;
        if (flat_reg)
        begin
            merge_data.nx = dcls_pkg::FLAT_NX;
            merge_data.ny = dcls_pkg::FLAT_NY;
            merge_data.nz = dcls_pkg::FLAT_NZ;
        end
        else
        begin
            merge_data.nx = nx_reg;
            merge_data.ny = ny_reg;
            merge_data.nz = nz_reg;
        end
        merge_data.red   = sr_reg[8] ? dcls_pkg::DEF_RED   : sr_reg[7:0];
        merge_data.green = sg_reg[8] ? dcls_pkg::DEF_GREEN : sg_reg[7:0];
        merge_data.blue  = sb_reg[8] ? dcls_pkg::DEF_BLUE  : sb_reg[7:0];
    end

    assign merge_win    = idx_ok && (depth_reg > rd_data.depth);
    assign covered_next = idx_ok && (rd_data.depth != 16'd0);

    dcls_pixel_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (mem_rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (mem_wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .clear_busy (clear_busy)
    );

    dcls_shade u_shade (
        .clk   (clk),
        .rst_n (rst_n),
        .light (light_reg),
        .req   (shade_req),
        .rsp   (shade_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dcls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dcls_pkg::ST_RMW;
                end
            end
            dcls_pkg::ST_RMW:
            begin
                if (op_reg == dcls_pkg::OP_MERGE)
                begin
                    state_next = dcls_pkg::ST_IDLE;
                end
                else if (covered_next)
                begin
                    state_next = dcls_pkg::ST_SHADE;
                end
                else
                begin
                    state_next = dcls_pkg::ST_EMIT;
                end
            end
            dcls_pkg::ST_SHADE:
            begin
                if (shade_rsp.done)
                begin
                    state_next = dcls_pkg::ST_EMIT;
                end
            end
            dcls_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = dcls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcls_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready        = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        wr_data         = merge_data;
        out_load        = 1'b0;
        shade_req.start = 1'b0;
        shade_req.nx    = rd_data.nx;
        shade_req.ny    = rd_data.ny;
        shade_req.nz    = rd_data.nz;
        shade_req.red   = rd_data.red;
        shade_req.green = rd_data.green;
        shade_req.blue  = rd_data.blue;
        case (state_reg)
            dcls_pkg::ST_IDLE:
            begin
                in_ready  = !clear_busy;
                mem_rd_en = in_valid && !clear_busy;
            end
            dcls_pkg::ST_RMW:
            begin
                if (op_reg == dcls_pkg::OP_MERGE)
                begin
                    mem_wr_en = merge_win;
                end
                else
                begin
                    mem_wr_en       = idx_ok;
                    wr_data         = '0;
                    shade_req.start = covered_next;
                end
            end
            dcls_pkg::ST_SHADE:
            begin
            end
            dcls_pkg::ST_EMIT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcls_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the coverage of the read
    always_ff @(posedge clk)
    begin
        if (state_reg == dcls_pkg::ST_RMW)
        begin
            covered_reg <= covered_next;
        end
    end

    // Output register: load a result, drop valid on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg   <= idx_reg;
            covered_out_reg <= covered_reg;
            if (covered_reg)
            begin
                alpha_reg <= dcls_pkg::ALPHA_ON;
                red_reg   <= shade_rsp.red;
                green_reg <= shade_rsp.green;
                blue_reg  <= shade_rsp.blue;
            end
            else if (transp_reg)
            begin
                alpha_reg <= dcls_pkg::ALPHA_OFF;
                red_reg   <= 8'd0;
                green_reg <= 8'd0;
                blue_reg  <= 8'd0;
            end
            else
            begin
                alpha_reg <= dcls_pkg::ALPHA_ON;
                red_reg   <= dcls_pkg::BG_RED;
                green_reg <= dcls_pkg::BG_GREEN;
                blue_reg  <= dcls_pkg::BG_BLUE;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign covered   = covered_out_reg;
    assign alpha     = alpha_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

`ifndef NO_ASSERTIONS
    // One item at a time: a transfer closes the input for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // Shade results arrive only while the sequencer waits for them
    a_shade_done: assert property (@(posedge clk) disable iff (!rst_n)
        shade_rsp.done |-> (state_reg == dcls_pkg::ST_SHADE))
        else $error("shade result outside shade wait");

    // No pixel write competes with the clearing pass
    a_no_wr_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !clear_busy)
        else $error("pixel write during clearing pass");

    // A new result comes only from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dcls_pkg::ST_EMIT))
        else $error("result raised outside emit step");
`endif

endmodule
